[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros
// concurrent assertion helpers clocked on i_clk, disabled while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition holds at every clock edge
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

`endif

[hw/rtl/ffwh_pkg.sv]
// ----------------------------------------------------------------------------
// ffwh_pkg
// types, widths, status codes and helpers of the first-fit word heap allocator
// ----------------------------------------------------------------------------
package ffwh_pkg;

    localparam int ARENA_WORDS = 1024;
    localparam int AW          = $clog2(ARENA_WORDS);
    localparam int IW          = AW + 1;
    localparam int HW          = AW + 2;

    localparam int SIZE_W      = 32;
    localparam int DIDX_W      = 10;
    localparam int UIDX_W      = 10;
    localparam int STATUS_W    = 3;

    typedef logic [AW-1:0]        t_addr;
    typedef logic [IW-1:0]        t_idx;
    typedef logic signed [HW-1:0] t_hdr;
    typedef logic [UIDX_W-1:0]    t_uidx;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 3'd0,
        ST_ZERO_SIZE    = 3'd1,
        ST_NO_SPACE     = 3'd2,
        ST_BAD_PTR      = 3'd3,
        ST_ALREADY_FREE = 3'd4,
        ST_ZERO_HEADER  = 3'd5
    } t_status;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    localparam t_hdr HDR_RESET = t_hdr'(-ARENA_WORDS);

    // block length at index i, cut at the arena end
    function automatic t_idx block_len(t_idx i, t_hdr h);
        logic [HW-1:0] mag;
        logic [HW-1:0] room;
        mag  = h[HW-1] ? HW'(-h) : HW'(h);
        room = HW'(ARENA_WORDS) - HW'(i);
        return (mag > room) ? IW'(room) : IW'(mag);
    endfunction

endpackage

[hw/rtl/first_fit_word_heap_allocator.sv]
// ----------------------------------------------------------------------------
// first_fit_word_heap_allocator
// first-fit allocator over an implicit list of signed block headers
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the header memory, one word a
// cycle, through all ARENA_WORDS (1024) words, and takes no request meanwhile.
// Each request is then handled one at a time by a sequencer around a header
// memory with one read and one write port: it takes the request, reads headers
// one at a time, and in a final step loads the result into the output
// register. An allocate walks the headers from the arena start, writing the
// remainder header first when a remainder is split off. A free reads the
// header of the freed block, merges the run of free blocks behind it and
// writes the merged header; an already free block or a zero header ends after
// the first header read. Zero size and bad pointer go straight to the final
// step. The final step waits while an earlier result is still stalled in the
// output register, and a new request is taken while that result still waits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module first_fit_word_heap_allocator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_operation,
    input  logic [ffwh_pkg::SIZE_W-1:0]        i_size_bytes,
    input  logic [ffwh_pkg::DIDX_W-1:0]        i_data_index,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [ffwh_pkg::STATUS_W-1:0]      o_status,
    output logic [ffwh_pkg::UIDX_W-1:0]        o_user_index
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_A_WALK,
        S_A_HDR,
        S_F_HEAD,
        S_F_MERGE,
        S_DONE
    } t_state;

    t_state            r_state, n_state;
    ffwh_pkg::t_idx    r_i, n_i;
    ffwh_pkg::t_idx    r_run, n_run;
    ffwh_pkg::t_idx    r_need, n_need;
    ffwh_pkg::t_idx    r_blk, n_blk;
    ffwh_pkg::t_idx    r_start, n_start;
    ffwh_pkg::t_status r_res_status, n_res_status;
    ffwh_pkg::t_uidx   r_res_uidx, n_res_uidx;
    logic              r_out_valid, n_out_valid;
    ffwh_pkg::t_status r_out_status, n_out_status;
    ffwh_pkg::t_uidx   r_out_uidx, n_out_uidx;

    ffwh_pkg::t_hdr    r_mem [ffwh_pkg::ARENA_WORDS];
    ffwh_pkg::t_hdr    r_rdata;
    ffwh_pkg::t_addr   rd_addr;
    logic              w_en;
    ffwh_pkg::t_addr   w_addr;
    ffwh_pkg::t_hdr    w_data;

    logic [ffwh_pkg::SIZE_W-1:0] c_need32;
    ffwh_pkg::t_idx    c_need;
    ffwh_pkg::t_idx    c_len;
    ffwh_pkg::t_idx    c_gap;
    ffwh_pkg::t_idx    c_start;
    ffwh_pkg::t_idx    c_split;
    ffwh_pkg::t_idx    c_nxt;
    ffwh_pkg::t_idx    c_blk;
    logic              c_step;
    logic              c_merge;

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_user_index = r_out_uidx;

    assign c_need32 = ((i_size_bytes - 32'd1) >> 2) + 32'd2;
    assign c_need   = (c_need32 > 32'(ffwh_pkg::ARENA_WORDS))
                    ? ffwh_pkg::t_idx'(ffwh_pkg::ARENA_WORDS + 1)
                    : ffwh_pkg::t_idx'(c_need32);

    always_comb begin
        n_state      = r_state;
        n_i          = r_i;
        n_run        = r_run;
        n_need       = r_need;
        n_blk        = r_blk;
        n_start      = r_start;
        n_res_status = r_res_status;
        n_res_uidx   = r_res_uidx;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_uidx   = r_out_uidx;
        rd_addr      = '0;
        w_en         = 1'b0;
        w_addr       = r_i[ffwh_pkg::AW-1:0];
        w_data       = '0;
        c_len        = ffwh_pkg::block_len(r_i, r_rdata);
        c_gap        = c_len + r_run;
        c_start      = r_i - r_run;
        c_split      = c_start + r_need;
        c_nxt        = r_i + c_len;
        c_blk        = c_len;
        c_step       = 1'b0;
        c_merge      = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                w_en   = 1'b1;
                w_data = (r_i == '0) ? ffwh_pkg::HDR_RESET : '0;
                n_i    = r_i + ffwh_pkg::t_idx'(1);
                if (r_i == ffwh_pkg::t_idx'(ffwh_pkg::ARENA_WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_res_uidx = '0;
                    if (i_operation == ffwh_pkg::OP_ALLOC) begin
                        if (i_size_bytes == '0) begin
                            n_res_status = ffwh_pkg::ST_ZERO_SIZE;
                            n_state      = S_DONE;
                        end else begin
                            n_need  = c_need;
                            n_i     = '0;
                            n_run   = '0;
                            n_state = S_A_WALK;
                        end
                    end else if (i_data_index == '0 ||
                                 32'(i_data_index) >= 32'(ffwh_pkg::ARENA_WORDS)) begin
                        n_res_status = ffwh_pkg::ST_BAD_PTR;
                        n_state      = S_DONE;
                    end else begin
                        n_i     = ffwh_pkg::t_idx'(32'(i_data_index) - 32'd1);
                        rd_addr = ffwh_pkg::t_addr'(32'(i_data_index) - 32'd1);
                        n_state = S_F_HEAD;
                    end
                end
            end
            S_A_WALK: begin
                if (r_rdata == '0) begin
                    n_res_status = ffwh_pkg::ST_ZERO_HEADER;
                    n_state      = S_DONE;
                end else if (!r_rdata[ffwh_pkg::HW-1]) begin
                    n_run  = '0;
                    c_step = 1'b1;
                end else if (c_gap >= r_need) begin
                    n_start = c_start;
                    w_en    = 1'b1;
                    if (c_gap > r_need) begin
                        w_addr  = c_split[ffwh_pkg::AW-1:0];
                        w_data  = -$signed({1'b0, ffwh_pkg::t_idx'(c_gap - r_need)});
                        n_state = S_A_HDR;
                    end else begin
                        w_addr       = c_start[ffwh_pkg::AW-1:0];
                        w_data       = $signed({1'b0, r_need});
                        n_res_status = ffwh_pkg::ST_OK;
                        n_res_uidx   = ffwh_pkg::t_uidx'(c_start + ffwh_pkg::t_idx'(1));
                        n_state      = S_DONE;
                    end
                end else begin
                    n_run  = c_gap;
                    c_step = 1'b1;
                end
                if (c_step) begin
                    n_i = c_nxt;
                    if (c_nxt >= ffwh_pkg::t_idx'(ffwh_pkg::ARENA_WORDS)) begin
                        n_res_status = ffwh_pkg::ST_NO_SPACE;
                        n_state      = S_DONE;
                    end else begin
                        rd_addr = c_nxt[ffwh_pkg::AW-1:0];
                    end
                end
            end
            S_A_HDR: begin
                w_en         = 1'b1;
                w_addr       = r_start[ffwh_pkg::AW-1:0];
                w_data       = $signed({1'b0, r_need});
                n_res_status = ffwh_pkg::ST_OK;
                n_res_uidx   = ffwh_pkg::t_uidx'(r_start + ffwh_pkg::t_idx'(1));
                n_state      = S_DONE;
            end
            S_F_HEAD: begin
                if (r_rdata[ffwh_pkg::HW-1]) begin
                    n_res_status = ffwh_pkg::ST_ALREADY_FREE;
                    n_state      = S_DONE;
                end else if (r_rdata == '0) begin
                    n_res_status = ffwh_pkg::ST_ZERO_HEADER;
                    n_state      = S_DONE;
                end else begin
                    c_blk   = c_len;
                    c_merge = 1'b1;
                end
            end
            S_F_MERGE: begin
                if (r_rdata[ffwh_pkg::HW-1]) begin
                    c_blk   = r_blk + ffwh_pkg::block_len(r_i + r_blk, r_rdata);
                    c_merge = 1'b1;
                end else begin
                    w_en         = 1'b1;
                    w_data       = -$signed({1'b0, r_blk});
                    n_res_status = ffwh_pkg::ST_OK;
                    n_state      = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_uidx   = r_res_uidx;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // follow the run of free blocks behind the freed one
        if (c_merge) begin
            n_blk = c_blk;
            if ((r_i + c_blk) < ffwh_pkg::t_idx'(ffwh_pkg::ARENA_WORDS)) begin
                rd_addr = ffwh_pkg::t_addr'(r_i + c_blk);
                n_state = S_F_MERGE;
            end else begin
                w_en         = 1'b1;
                w_data       = -$signed({1'b0, c_blk});
                n_res_status = ffwh_pkg::ST_OK;
                n_state      = S_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_i         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_i         <= n_i;
            r_out_valid <= n_out_valid;
        end
        r_run        <= n_run;
        r_need       <= n_need;
        r_blk        <= n_blk;
        r_start      <= n_start;
        r_res_status <= n_res_status;
        r_res_uidx   <= n_res_uidx;
        r_out_status <= n_out_status;
        r_out_uidx   <= n_out_uidx;
    end

    // header memory
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= w_data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    `ASSERT_IMPL(a_write_when_busy, w_en, (r_state != S_IDLE && r_state != S_DONE), "header write outside a request")
    `ASSERT_IMPL(a_hdr_after_split, r_state == S_A_HDR, $past(w_en), "header write without remainder write")
    `ASSERT_IMPL(a_walk_in_arena, r_state == S_A_WALK, r_i < ffwh_pkg::t_idx'(ffwh_pkg::ARENA_WORDS), "walk index past arena")
    `ASSERT_ALWAYS(a_uidx_only_ok, (!o_out_valid || o_status == ffwh_pkg::ST_OK || o_user_index == '0), "user index set on failed transfer")

endmodule
